### src/debug_register_file_guard_defines.svh
// assertion macros for the debug register file guard
`ifndef DEBUG_REGISTER_FILE_GUARD_DEFINES_SVH
`define DEBUG_REGISTER_FILE_GUARD_DEFINES_SVH

`ifndef SYNTH
// checked property, idle while reset is asserted
`define DRFG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked property that also holds through reset
`define DRFG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DRFG_ASSERT(label, prop, msg)
`define DRFG_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### src/drfg_pkg.sv
package drfg_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned SEL_W      = 16;
    localparam int unsigned NUM_WORDS  = 8;
    localparam int unsigned WORD_IDX_W = $clog2(NUM_WORDS);
    localparam int unsigned REG_IDX_W  = 4;
    localparam int unsigned CFG_IDX_W  = 2;

    localparam logic [WORD_W-1:0] DR6_ZERO_MASK = 32'hffffefff;
    localparam logic [WORD_W-1:0] DR6_ONE_MASK  = 32'hffff0ff0;
    localparam logic [WORD_W-1:0] DR7_ZERO_MASK = 32'hffff27ff;
    localparam logic [WORD_W-1:0] DR7_ONE_MASK  = 32'h00000400;
    localparam int unsigned       DR7_GD_BIT    = 13;
    localparam int unsigned       TF_BIT        = 8;

    localparam logic [WORD_W-1:0] ADDR_LIMIT_RESET = 32'hbffffffc;

    localparam logic [WORD_IDX_W-1:0] STATUS_WORD  = 3'd6;
    localparam logic [WORD_IDX_W-1:0] CONTROL_WORD = 3'd7;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_EVENT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_DENIED  = 2'd1,
        STATUS_INVALID = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ADDR_LIMIT  = 2'd0,
        CFG_HANDLER_SEL = 2'd1,
        CFG_HANDLER_ADR = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // true when any r/w or len field of the control word holds the reserved code
    function automatic logic dr7_bad_field(input logic [WORD_W-1:0] v);
        logic bad;
        bad = 1'b0;
        for (int i = 16; i < 32; i += 2)
        begin
            if (v[i +: 2] == 2'b10)
            begin
                bad = 1'b1;
            end
        end
        return bad;
    endfunction

endpackage

### src/drfg_if.sv
interface drfg_req_if;
    import drfg_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [REG_IDX_W-1:0] reg_index;
    logic [WORD_W-1:0]    write_value;
    logic [WORD_W-1:0]    condition;
    logic [1:0]           ring;
    logic [WORD_W-1:0]    flags_in;

    modport source (output valid, kind, reg_index, write_value, condition, ring, flags_in,
                    input ready);
    modport sink   (input valid, kind, reg_index, write_value, condition, ring, flags_in,
                    output ready);
endinterface

interface drfg_rsp_if;
    import drfg_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [WORD_W-1:0] read_data;
    logic              clear_control;
    logic              bounce;
    logic [SEL_W-1:0]  bounce_selector;
    logic [WORD_W-1:0] bounce_address;
    logic [WORD_W-1:0] flags_out;

    modport source (output valid, status, read_data, clear_control, bounce, bounce_selector,
                    bounce_address, flags_out, input ready);
    modport sink   (input valid, status, read_data, clear_control, bounce, bounce_selector,
                    bounce_address, flags_out, output ready);
endinterface

### src/drfg_ram.sv
module drfg_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### src/debug_register_file_guard.sv
// channel   | role   | payload
// ----------+--------+----------------------------------------------------------------
// request   | sink   | kind, reg_index, write_value, condition, ring, flags_in
// response  | source | status, read_data, clear_control, bounce, bounce_selector,
//           |        | bounce_address, flags_out
// cfg_*     | write  | cfg_we, cfg_index, cfg_wdata (address limit, handler selector/address)
//
// every transaction reads the word ram as the request is taken, then checks and writes back in the execute state
// a new request is taken once the previous one has left the execute state
// the response register lets the next request in while a result still waits
// a stalled response holds the execute state until the result register frees up
// reset clears the per-word valid bits, so all words read zero without a clearing pass

`include "debug_register_file_guard_defines.svh"

module debug_register_file_guard (
    input  logic                            clk,
    input  logic                            rst_n,
    drfg_req_if.sink                        request,
    drfg_rsp_if.source                      response,
    input  logic                            cfg_we,
    input  logic [drfg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [drfg_pkg::WORD_W-1:0]     cfg_wdata
);

    import drfg_pkg::*;

    // configuration registers
    logic [WORD_W-1:0] addr_limit_reg;
    logic [SEL_W-1:0]  handler_sel_reg;
    logic [WORD_W-1:0] handler_adr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_limit_reg  <= ADDR_LIMIT_RESET;
            handler_sel_reg <= '0;
            handler_adr_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_ADDR_LIMIT:  addr_limit_reg  <= cfg_wdata;
                CFG_HANDLER_SEL: handler_sel_reg <= cfg_wdata[SEL_W-1:0];
                CFG_HANDLER_ADR: handler_adr_reg <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // sequencer
    state_t state_reg, state_next;
    logic   req_accept;
    logic   exec_done;
    logic   out_valid_reg;

    // captured request
    logic [1:0]           kind_reg;
    logic [REG_IDX_W-1:0] idx_reg;
    logic [WORD_W-1:0]    wval_reg;
    logic [WORD_W-1:0]    cond_reg;
    logic [1:0]           ring_reg;
    logic [WORD_W-1:0]    flags_reg;

    // word ram and its valid bits
    logic [NUM_WORDS-1:0]  word_valid_reg;
    logic                  rd_valid_reg;
    logic                  ram_re;
    logic [WORD_IDX_W-1:0] ram_raddr;
    logic [WORD_W-1:0]     ram_rdata;
    logic                  ram_we;
    logic [WORD_IDX_W-1:0] ram_waddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     rd_word;

    // result of the execute step
    status_t           res_status;
    logic [WORD_W-1:0] res_read;
    logic              res_clear;
    logic              res_bounce;
    logic [SEL_W-1:0]  res_sel;
    logic [WORD_W-1:0] res_adr;
    logic [WORD_W-1:0] res_flags;
    logic              wr_ok;
    logic [WORD_W-1:0] dr7_val;

    drfg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_WORDS)
    ) u_words (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state, handshake and ram read port
    always_comb
    begin
        state_next    = state_reg;
        request.ready = 1'b0;
        exec_done     = 1'b0;
        ram_re        = 1'b0;
        // an event needs the control word, a read needs the addressed word
        ram_raddr     = (kind_t'(request.kind) == KIND_EVENT) ? CONTROL_WORD
                                                              : request.reg_index[WORD_IDX_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                request.ready = 1'b1;
                if (request.valid)
                begin
                    ram_re     = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // result register free or being emptied this cycle
                if (!out_valid_reg || response.ready)
                begin
                    exec_done  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_accept = request.valid && request.ready;

    // capture the request and the valid bit of the word being read
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            kind_reg     <= request.kind;
            idx_reg      <= request.reg_index;
            wval_reg     <= request.write_value;
            cond_reg     <= request.condition;
            ring_reg     <= request.ring;
            flags_reg    <= request.flags_in;
            rd_valid_reg <= word_valid_reg[ram_raddr];
        end
    end

    // a word never written reads as zero
    assign rd_word = rd_valid_reg ? ram_rdata : '0;

    // reserved bits forced on a nonzero control write
    assign dr7_val = (wval_reg & DR7_ZERO_MASK) | DR7_ONE_MASK;

    // checks and write-back
    always_comb
    begin
        res_status = STATUS_OK;
        res_read   = '0;
        res_clear  = 1'b0;
        res_bounce = 1'b0;
        res_sel    = '0;
        res_adr    = '0;
        res_flags  = '0;
        wr_ok      = 1'b0;
        ram_waddr  = idx_reg[WORD_IDX_W-1:0];
        ram_wdata  = wval_reg;
        case (kind_reg)
            KIND_WRITE:
            begin
                if (idx_reg inside {[4'd0:4'd3]})
                begin
                    // breakpoint address above the limit is refused
                    if (wval_reg > addr_limit_reg)
                    begin
                        res_status = STATUS_DENIED;
                    end
                    else
                    begin
                        wr_ok = 1'b1;
                    end
                end
                else if (idx_reg == {1'b0, STATUS_WORD})
                begin
                    ram_wdata = (wval_reg & DR6_ZERO_MASK) | DR6_ONE_MASK;
                    wr_ok     = 1'b1;
                end
                else if (idx_reg == {1'b0, CONTROL_WORD})
                begin
                    if (wval_reg == '0)
                    begin
                        // debugging switched off, no checks
                        wr_ok = 1'b1;
                    end
                    else if (dr7_val[DR7_GD_BIT] || dr7_bad_field(dr7_val))
                    begin
                        res_status = STATUS_DENIED;
                    end
                    else
                    begin
                        ram_wdata = dr7_val;
                        wr_ok     = 1'b1;
                    end
                end
                else
                begin
                    res_status = STATUS_INVALID;
                end
            end
            KIND_READ:
            begin
                if (idx_reg[REG_IDX_W-1])
                begin
                    res_status = STATUS_INVALID;
                end
                else
                begin
                    res_read = rd_word;
                end
            end
            KIND_EVENT:
            begin
                res_flags = flags_reg;
                if ((cond_reg[3:0] != 4'd0) && (rd_word == '0))
                begin
                    // breakpoint hit with debugging off: spurious
                    res_clear = 1'b1;
                end
                else if (ring_reg == 2'd0)
                begin
                    res_flags[TF_BIT] = 1'b0;
                end
                else
                begin
                    // record the condition and hand the event to the guest
                    ram_waddr  = STATUS_WORD;
                    ram_wdata  = cond_reg;
                    wr_ok      = 1'b1;
                    res_bounce = 1'b1;
                    res_sel    = handler_sel_reg;
                    res_adr    = handler_adr_reg;
                end
            end
            default:
            begin
                res_status = STATUS_INVALID;
            end
        endcase
    end

    assign ram_we = exec_done && wr_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
        end
        else if (ram_we)
        begin
            word_valid_reg[ram_waddr] <= 1'b1;
        end
    end

    // result register
    logic [1:0]        status_reg;
    logic [WORD_W-1:0] read_data_reg;
    logic              clear_reg;
    logic              bounce_reg;
    logic [SEL_W-1:0]  sel_reg;
    logic [WORD_W-1:0] adr_reg;
    logic [WORD_W-1:0] flags_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (exec_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_done)
        begin
            status_reg    <= res_status;
            read_data_reg <= res_read;
            clear_reg     <= res_clear;
            bounce_reg    <= res_bounce;
            sel_reg       <= res_sel;
            adr_reg       <= res_adr;
            flags_out_reg <= res_flags;
        end
    end

    assign response.valid           = out_valid_reg;
    assign response.status          = status_reg;
    assign response.read_data       = read_data_reg;
    assign response.clear_control   = clear_reg;
    assign response.bounce          = bounce_reg;
    assign response.bounce_selector = sel_reg;
    assign response.bounce_address  = adr_reg;
    assign response.flags_out       = flags_out_reg;

    // an accepted request always moves to the execute step
    `DRFG_ASSERT(a_accept_exec, req_accept |=> (state_reg == ST_EXEC), "accept not followed by execute")
    // a finished execute step always leaves a result waiting
    `DRFG_ASSERT(a_done_valid, exec_done |=> out_valid_reg, "result lost after execute")
    // a bounced event never also asks for the control clear
    `DRFG_ASSERT(a_bounce_clear, (response.valid && response.bounce) |-> !response.clear_control, "bounce and clear together")
    // the word ram is never written outside the execute step
    `DRFG_ASSERT_ALWAYS(a_we_exec, ram_we |-> (state_reg == ST_EXEC), "word write outside execute")

endmodule
